### rtl/frt_pkg.sv
// Shared types and codes for the first-match route table.
// Depends on nothing; imported by the cell and the top level.
`timescale 1ns / 1ps

package frt_pkg;

  localparam logic [1:0] CMD_APPEND = 2'd0;
  localparam logic [1:0] CMD_LOOKUP = 2'd1;
  localparam logic [1:0] CMD_CLEAR  = 2'd2;

  localparam logic [2:0] ST_ADDED    = 3'd0;
  localparam logic [2:0] ST_FULL     = 3'd1;
  localparam logic [2:0] ST_MATCH    = 3'd2;
  localparam logic [2:0] ST_FALLBACK = 3'd3;
  localparam logic [2:0] ST_EMPTY    = 3'd4;
  localparam logic [2:0] ST_CLEARED  = 3'd5;

  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] route_prefix;
    logic [31:0] next_hop;
    logic [31:0] prefix_mask;
    logic [7:0]  route_flags;
    logic [31:0] route_metric;
    logic [1:0]  device_index;
    logic [31:0] lookup_addr;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] out_prefix;
    logic [31:0] out_next_hop;
    logic [31:0] out_mask;
    logic [7:0]  out_flags;
    logic [31:0] out_metric;
    logic [1:0]  out_device;
    logic [3:0]  out_slot;
  } rsp_t;

  typedef struct packed {
    logic [31:0] prefix;
    logic [31:0] next_hop;
    logic [31:0] mask;
    logic [7:0]  flags;
    logic [31:0] metric;
    logic [1:0]  device;
  } entry_t;

  // Search token handed from cell to cell during a lookup.
  typedef struct packed {
    logic        valid;
    logic        found;
    logic [31:0] addr;
    entry_t      entry;
    logic [3:0]  slot;
  } token_t;

endpackage

### rtl/frt_cell.sv
// One route slot of the table plus one stage of the search chain.
// Depends on frt_pkg.
`timescale 1ns / 1ps

module frt_cell
  import frt_pkg::*;
#(
  parameter int CELL_INDEX = 0,
  parameter int CNT_W      = 5
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  entry_t           wr_entry,
  input  logic [CNT_W-1:0] count,
  input  token_t           tok_in,
  output token_t           tok_out
);

  localparam logic [CNT_W-1:0] IDX = CNT_W'(CELL_INDEX);

  entry_t entry;
  token_t tok_next;
  logic   live;
  logic   hit;
  logic   last;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      entry <= wr_entry;
    end
  end

  always_comb begin
    live = count > IDX;
    last = count == IDX + CNT_W'(1);
    hit  = live && ((tok_in.addr & entry.mask) == (entry.prefix & entry.mask));
    tok_next = tok_in;
    // The last live cell loads itself as the fallback answer when nothing matched.
    if (tok_in.valid && !tok_in.found && (hit || last)) begin
      tok_next.found = hit;
      tok_next.entry = entry;
      tok_next.slot  = 4'(CELL_INDEX);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.valid <= 1'b0;
    end else begin
      tok_out.valid <= tok_next.valid;
    end
    tok_out.found <= tok_next.found;
    tok_out.addr  <= tok_next.addr;
    tok_out.entry <= tok_next.entry;
    tok_out.slot  <= tok_next.slot;
  end

endmodule

### rtl/first_match_route_table.sv
// Top level of the first-match route table: command decode, entry count,
// result register and the chain of frt_cell slots. Depends on frt_pkg, frt_cell.
`timescale 1ns / 1ps

// An ordered route table of ENTRIES slots, searched first to last. A command
// beat is taken at a rising edge where start is high and busy is low. Append,
// clear, and a lookup on an empty table answer in the cycle after the beat and
// leave busy low, so such commands can be issued every cycle. A lookup on a
// non-empty table sends a search token down the row of cells, one cell per
// cycle, through the register of every one of the ENTRIES cells and then the
// result register, and busy stays high meanwhile. Every result is shown on the
// result port for exactly one cycle with done high, and the receiver cannot
// hold it off. Command code 3 is taken and produces no result.
module first_match_route_table
  import frt_pkg::*;
#(
  parameter int ENTRIES = 16,
  parameter int DEVICES = 4
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  req_t request,
  output logic busy,
  output logic done,
  output rsp_t result
);

  localparam int CNT_W   = $clog2(ENTRIES + 1);
  // A 2-bit device field can never reach DEVICES when DEVICES is 4 or more.
  localparam int DEV_MAX = ((DEVICES > 4) ? 4 : DEVICES) - 1;
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(ENTRIES);

  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic             busy_next;
  logic             done_next;
  rsp_t             result_next;
  logic             accept;
  logic             append_ok;
  entry_t           new_entry;
  token_t           tok [ENTRIES+1];

  assign accept = start && !busy;

  // The route being appended, with out-of-range device numbers clamped.
  always_comb begin
    new_entry.prefix   = request.route_prefix;
    new_entry.next_hop = request.next_hop;
    new_entry.mask     = request.prefix_mask;
    new_entry.flags    = request.route_flags;
    new_entry.metric   = request.route_metric;
    new_entry.device   = request.device_index;
    if (32'(request.device_index) > DEV_MAX) begin
      new_entry.device = 2'(DEV_MAX);
    end
  end

  assign append_ok = accept && (request.command == CMD_APPEND) && (count < FULL_CNT);

  // Search token entering the first cell.
  always_comb begin
    tok[0]       = '0;
    tok[0].valid = accept && (request.command == CMD_LOOKUP) && (count != '0);
    tok[0].addr  = request.lookup_addr;
  end

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    frt_cell #(
      .CELL_INDEX (i),
      .CNT_W      (CNT_W)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .wr_en    (append_ok && (count == CNT_W'(i))),
      .wr_entry (new_entry),
      .count    (count),
      .tok_in   (tok[i]),
      .tok_out  (tok[i+1])
    );
  end

  always_comb begin
    count_next  = count;
    busy_next   = busy;
    done_next   = 1'b0;
    result_next = '0;
    if (tok[ENTRIES].valid) begin
      // The search token left the last cell: report what it carries.
      busy_next               = 1'b0;
      done_next               = 1'b1;
      result_next.status      = tok[ENTRIES].found ? ST_MATCH : ST_FALLBACK;
      result_next.out_prefix  = tok[ENTRIES].entry.prefix;
      result_next.out_next_hop = tok[ENTRIES].entry.next_hop;
      result_next.out_mask    = tok[ENTRIES].entry.mask;
      result_next.out_flags   = tok[ENTRIES].entry.flags;
      result_next.out_metric  = tok[ENTRIES].entry.metric;
      result_next.out_device  = tok[ENTRIES].entry.device;
      result_next.out_slot    = tok[ENTRIES].slot;
    end else if (accept) begin
      unique case (request.command)
        CMD_APPEND: begin
          done_next = 1'b1;
          if (count < FULL_CNT) begin
            result_next.status   = ST_ADDED;
            result_next.out_slot = 4'(count);
            count_next           = count + CNT_W'(1);
          end else begin
            result_next.status = ST_FULL;
          end
        end
        CMD_LOOKUP: begin
          if (count == '0) begin
            done_next          = 1'b1;
            result_next.status = ST_EMPTY;
          end else begin
            busy_next = 1'b1;
          end
        end
        CMD_CLEAR: begin
          done_next          = 1'b1;
          result_next.status = ST_CLEARED;
          count_next         = '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      busy  <= 1'b0;
      done  <= 1'b0;
    end else begin
      count <= count_next;
      busy  <= busy_next;
      done  <= done_next;
    end
    result <= result_next;
  end

endmodule

### dv/tb_first_match_route_table.sv
// Self-checking testbench for first_match_route_table: directed and random command beats,
// with a predictor of the table's contents and a result checker. Depends on frt_pkg and the RTL.
`timescale 1ns / 1ps

module tb_first_match_route_table;
  import frt_pkg::*;

  localparam int ENTRIES = 16;
  localparam int DEVICES = 4;

  // The package names three commands; the fourth code is reserved and must be
  // swallowed by the block without an answer.
  localparam logic [1:0] CMD_RESERVED = 2'd3;

  // The watchdog fires after this many cycles in which no beat is taken and no
  // result appears. The longest quiet stretch in a correct run is a sender gap
  // or a lookup in flight, and this limit is several times over either.
  localparam int QUIET_LIMIT = 400;

  logic clk;
  logic rst;
  logic start;
  req_t request;
  logic busy;
  logic done;
  rsp_t result;

  first_match_route_table #(
    .ENTRIES(ENTRIES),
    .DEVICES(DEVICES)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .start(start),
    .request(request),
    .busy(busy),
    .done(done),
    .result(result)
  );

  // Shadow copy of the route table, updated in command order as beats are
  // taken. Only slots below table_size are ever read.
  entry_t route_table[ENTRIES];
  int table_size;

  // Answers the block owes us, oldest first.
  rsp_t owed_answers[$];

  int error_count;
  int answers_checked;
  int ignored_beats;
  int status_tally[6];
  int quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // One line per mismatch, and a running count that decides the verdict.
  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t ns: MISMATCH %s: got 0x%08h, expected 0x%08h", $time, what, got, want);
    error_count++;
  endtask

  // Applies one accepted command to the shadow table and queues the answer it
  // must produce. Appends land in the next free slot; a lookup scans from slot
  // zero and the first masked-prefix hit wins. With no hit, the last stored
  // route comes back as the fallback.
  task automatic predict_route_answer(input req_t beat);
    rsp_t ans;
    int hit;
    int slot;
    logic [1:0] dev;
    ans = '0;
    case (beat.command)
      CMD_APPEND: begin
        if (table_size >= ENTRIES) begin
          ans.status = ST_FULL;
        end else begin
          // An interface index beyond the configured count is pinned to the
          // highest one.
          dev = beat.device_index;
          if (int'(dev) >= DEVICES) dev = 2'(DEVICES - 1);
          route_table[table_size] = '{prefix: beat.route_prefix, next_hop: beat.next_hop,
                                      mask: beat.prefix_mask, flags: beat.route_flags,
                                      metric: beat.route_metric, device: dev};
          ans.status = ST_ADDED;
          ans.out_slot = 4'(table_size);
          table_size++;
        end
      end
      CMD_LOOKUP: begin
        if (table_size == 0) begin
          ans.status = ST_EMPTY;
        end else begin
          hit = -1;
          for (int i = 0; i < table_size; i++) begin
            if (hit < 0 && (beat.lookup_addr & route_table[i].mask) ==
                (route_table[i].prefix & route_table[i].mask)) hit = i;
          end
          ans.status = (hit >= 0) ? ST_MATCH : ST_FALLBACK;
          slot = (hit >= 0) ? hit : table_size - 1;
          ans.out_prefix = route_table[slot].prefix;
          ans.out_next_hop = route_table[slot].next_hop;
          ans.out_mask = route_table[slot].mask;
          ans.out_flags = route_table[slot].flags;
          ans.out_metric = route_table[slot].metric;
          ans.out_device = route_table[slot].device;
          ans.out_slot = 4'(slot);
        end
      end
      CMD_CLEAR: begin
        // The stored routes stay in place but become unreachable.
        table_size = 0;
        ans.status = ST_CLEARED;
      end
      default: begin
        ignored_beats++;
        return;
      end
    endcase
    status_tally[ans.status]++;
    owed_answers.push_back(ans);
  endtask

  // A beat full of random bits with the given command. Fields the command does
  // not use carry junk on purpose.
  function automatic req_t random_beat(input logic [1:0] cmd);
    req_t b;
    b.command = cmd;
    b.route_prefix = $urandom;
    b.next_hop = $urandom;
    b.prefix_mask = $urandom;
    b.route_flags = 8'($urandom);
    b.route_metric = $urandom;
    b.device_index = 2'($urandom);
    b.lookup_addr = $urandom;
    return b;
  endfunction

  function automatic req_t append_beat(input logic [31:0] prefix, input logic [31:0] hop,
                                       input logic [31:0] mask, input logic [7:0] flags,
                                       input logic [31:0] metric, input logic [1:0] dev);
    req_t b;
    b = random_beat(CMD_APPEND);
    b.route_prefix = prefix;
    b.next_hop = hop;
    b.prefix_mask = mask;
    b.route_flags = flags;
    b.route_metric = metric;
    b.device_index = dev;
    return b;
  endfunction

  function automatic req_t lookup_beat(input logic [31:0] addr);
    req_t b;
    b = random_beat(CMD_LOOKUP);
    b.lookup_addr = addr;
    return b;
  endfunction

  // Contiguous netmask of the given prefix length, 0 to 32.
  function automatic logic [31:0] netmask(input int len);
    return (len == 0) ? 32'h0 : ~32'h0 << (32 - len);
  endfunction

  // Presents one beat from the falling edge and holds it until a rising edge
  // finds busy low. start is left high so the next beat can follow at once.
  task automatic send_beat(input req_t beat);
    @(negedge clk);
    start = 1'b1;
    request = beat;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_route_answer(beat);
  endtask

  // Drops start for the given number of cycles while the request bus carries
  // noise that the block must ignore.
  task automatic idle_for(input int cycles);
    repeat (cycles) begin
      @(negedge clk);
      start = 1'b0;
      request = random_beat(2'($urandom));
    end
  endtask

  // Holds off the sender until every owed answer has come back.
  task automatic hold_until_answered();
    @(negedge clk);
    start = 1'b0;
    while (owed_answers.size() != 0) @(negedge clk);
  endtask

  // A lookup and a clear on the table straight out of reset.
  task automatic test_empty_table();
    send_beat(lookup_beat(32'h0));
    send_beat(random_beat(CMD_CLEAR));
  endtask

  // Overlapping routes where an earlier, shorter prefix must shadow a later,
  // longer one; an all-ones host route; a miss that falls back to the last
  // entry; and a reserved command code that must produce nothing.
  task automatic test_first_match_order();
    send_beat(append_beat(32'h0A00_0000, 32'h0, 32'hFF00_0000, 8'h00, 32'h0, 2'd0));
    send_beat(append_beat(32'h0A01_0000, 32'hC0A8_0001, 32'hFFFF_0000, 8'h5A, 32'd100, 2'd1));
    send_beat(append_beat(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFFF,
                          2'd3));
    send_beat(lookup_beat(32'h0A01_0203));
    send_beat(lookup_beat(32'hFFFF_FFFF));
    send_beat(lookup_beat(32'h0000_0000));
    send_beat(random_beat(CMD_RESERVED));
  endtask

  // Fills the remaining slots with host routes and a default route at the end,
  // then appends once more so the route is dropped; clears and looks again.
  task automatic test_table_full();
    repeat (ENTRIES - 4) send_beat(append_beat($urandom, $urandom, 32'hFFFF_FFFF,
                                               8'($urandom), $urandom, 2'($urandom)));
    send_beat(append_beat($urandom, 32'h0, 32'h0, 8'($urandom), $urandom, 2'd2));
    send_beat(random_beat(CMD_APPEND));
    send_beat(lookup_beat($urandom));
    send_beat(random_beat(CMD_CLEAR));
    send_beat(lookup_beat($urandom));
  endtask

  // Random traffic weighted toward appends and lookups. Most lookups aim inside
  // a stored route so matches are common, and new prefixes often nest inside
  // existing ones so the scan order matters. The sender runs in bursts, some
  // with no gaps at all, and waits for all answers once in the middle and at random.
  task automatic test_random_traffic(input int n_items);
    int sent;
    int burst_left;
    int pick;
    int idx;
    bit held;
    logic [31:0] mask;
    logic [31:0] base;
    req_t b;
    sent = 0;
    burst_left = 0;
    held = 1'b0;
    while (sent < n_items) begin
      if (burst_left == 0) begin
        if ($urandom_range(0, 3) == 0) begin
          burst_left = $urandom_range(20, 60);
        end else begin
          burst_left = $urandom_range(1, 8);
          idle_for($urandom_range(1, 20));
        end
      end
      if ((!held && sent >= n_items / 2) || $urandom_range(0, 79) == 0) begin
        hold_until_answered();
        held = 1'b1;
      end
      pick = $urandom_range(0, 99);
      if (pick < 44) begin
        mask = ($urandom_range(0, 7) == 0) ? $urandom : netmask($urandom_range(0, 32));
        b = random_beat(CMD_APPEND);
        if (table_size > 0 && $urandom_range(0, 2) == 0) begin
          idx = $urandom_range(0, table_size - 1);
          base = route_table[idx].prefix & route_table[idx].mask;
          b.route_prefix = base | ($urandom & ~route_table[idx].mask);
        end
        b.prefix_mask = mask;
      end else if (pick < 88) begin
        b = random_beat(CMD_LOOKUP);
        if (table_size > 0 && $urandom_range(0, 3) != 0) begin
          idx = $urandom_range(0, table_size - 1);
          b.lookup_addr = (route_table[idx].prefix & route_table[idx].mask) |
                          ($urandom & ~route_table[idx].mask);
        end
      end else if (pick < 94) begin
        b = random_beat(CMD_CLEAR);
      end else begin
        b = random_beat(CMD_RESERVED);
      end
      send_beat(b);
      if (b.command != CMD_RESERVED) sent++;
      burst_left--;
    end
  endtask

  // Every answer is on the port for one cycle only, so each done cycle is
  // checked against the oldest owed answer, field by field.
  always @(posedge clk) begin : check_answers
    rsp_t want;
    if (!rst && done) begin
      if (owed_answers.size() == 0) begin
        report_mismatch("answer with none owed, status", 32'(result.status), 32'h0);
      end else begin
        want = owed_answers.pop_front();
        answers_checked++;
        if (result.status !== want.status)
          report_mismatch("status", 32'(result.status), 32'(want.status));
        if (result.out_prefix !== want.out_prefix)
          report_mismatch("out_prefix", result.out_prefix, want.out_prefix);
        if (result.out_next_hop !== want.out_next_hop)
          report_mismatch("out_next_hop", result.out_next_hop, want.out_next_hop);
        if (result.out_mask !== want.out_mask)
          report_mismatch("out_mask", result.out_mask, want.out_mask);
        if (result.out_flags !== want.out_flags)
          report_mismatch("out_flags", 32'(result.out_flags), 32'(want.out_flags));
        if (result.out_metric !== want.out_metric)
          report_mismatch("out_metric", result.out_metric, want.out_metric);
        if (result.out_device !== want.out_device)
          report_mismatch("out_device", 32'(result.out_device), 32'(want.out_device));
        if (result.out_slot !== want.out_slot)
          report_mismatch("out_slot", 32'(result.out_slot), 32'(want.out_slot));
      end
    end
  end

  // A stretch with no beat taken and no answer given means the block hung.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles + 1 >= QUIET_LIMIT) begin
        $display("%0t ns: no progress for %0d cycles", $time, QUIET_LIMIT);
        $display("first_match_route_table verification failed");
        $finish;
      end
    end
  end

  initial begin
    rst = 1'b1;
    start = 1'b0;
    request = '0;
    table_size = 0;
    error_count = 0;
    answers_checked = 0;
    ignored_beats = 0;
    quiet_cycles = 0;
    foreach (status_tally[i]) status_tally[i] = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_empty_table();
    test_first_match_order();
    test_table_full();
    test_random_traffic(620);

    // Let the last answers drain, then give a reserved-code beat or a late
    // lookup time to show anything it should not.
    hold_until_answered();
    repeat (ENTRIES + 4) @(posedge clk);

    $display("Covered %0d appends, %0d drops on a full table, %0d first matches, %0d fallbacks,",
             status_tally[ST_ADDED], status_tally[ST_FULL], status_tally[ST_MATCH],
             status_tally[ST_FALLBACK]);
    $display("%0d empty lookups, %0d clears and %0d reserved codes; %0d answers checked.",
             status_tally[ST_EMPTY], status_tally[ST_CLEARED], ignored_beats, answers_checked);
    if (error_count == 0 && owed_answers.size() == 0) begin
      $display("first_match_route_table verification clean");
    end else begin
      $display("first_match_route_table verification failed");
    end
    $finish;
  end

endmodule
